>>> rtl/kbt_pkg.sv
`default_nettype none

package kbt_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned KBT_MAX_KEY     = 8;
  localparam int unsigned KBT_SYMBOL_BITS = 8;
  localparam int unsigned KBT_MIN_KEY     = 3;

  // Fixed field widths
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 64;

  // Block queue between front and back
  localparam int unsigned QDEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SYMBOLS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_SYMBOL  = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_KEY = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             block_end;
    logic             text_end;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic             direction;
    logic [LEN_W-1:0] key_length;
    logic [KEY_W-1:0] key_symbols;
    logic [SYM_W-1:0] pad_symbol;
  } cfg_t;

  // Per-block control carried through the queue
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             last;
    logic [1:0]       status;
  } blk_ctl_t;

endpackage

`default_nettype wire

>>> rtl/kbt_front.sv
`default_nettype none

module kbt_front
  import kbt_pkg::*;
#(
  parameter int unsigned MAX_KEY     = KBT_MAX_KEY,
  parameter int unsigned SYMBOL_BITS = KBT_SYMBOL_BITS,
  localparam int unsigned IW = $clog2(MAX_KEY),
  localparam int unsigned CW = $clog2(MAX_KEY + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire cfg_t                            cfg_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire in_item_t                        in_item_i,
  input  wire logic                            q_full_i,
  output logic                                 push_o,
  output logic [MAX_KEY-1:0][SYM_W-1:0]        syms_o,
  output logic [MAX_KEY-1:0][IW-1:0]           sel_o,
  output blk_ctl_t                             ctl_o
);

  localparam logic [SYM_W-1:0] SymMask =
    (SYMBOL_BITS >= SYM_W) ? {SYM_W{1'b1}} : SYM_W'((1 << SYMBOL_BITS) - 1);

  logic [CW-1:0]                fill_q, fill_d;
  logic [MAX_KEY-1:0][SYM_W-1:0] store_q;

  logic                          in_acc;
  logic [SYM_W-1:0]              sym_m, pad_m;
  logic [MAX_KEY-1:0][SYM_W-1:0] key_m;
  logic                          key_ok;
  logic [MAX_KEY-1:0][IW-1:0]    rank, ord;
  logic                          room;
  logic [CW-1:0]                 fill_new;
  logic                          short_blk;

  assign in_stall_o = q_full_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sym_m      = in_item_i.symbol & SymMask;
  assign pad_m      = cfg_i.pad_symbol & SymMask;
  assign room       = (fill_q < CW'(MAX_KEY));
  assign fill_new   = room ? fill_q + CW'(1) : fill_q;
  assign short_blk  = (LEN_W'(fill_new) < cfg_i.key_length);

  // Key slots, duplicate check and ranks by unsigned code
  always_comb begin
    logic dup;
    dup = 1'b0;
    for (int k = 0; k < MAX_KEY; k++) begin
      key_m[k] = cfg_i.key_symbols[8*k +: SYM_W] & SymMask;
    end
    for (int a = 0; a < MAX_KEY; a++) begin
      for (int b = a + 1; b < MAX_KEY; b++) begin
        if ((LEN_W'(b) < cfg_i.key_length) && (key_m[a] == key_m[b])) begin
          dup = 1'b1;
        end
      end
    end
    key_ok = !dup && (cfg_i.key_length >= LEN_W'(KBT_MIN_KEY))
             && (cfg_i.key_length <= LEN_W'(MAX_KEY));
    for (int p = 0; p < MAX_KEY; p++) begin
      rank[p] = '0;
      for (int q = 0; q < MAX_KEY; q++) begin
        if ((LEN_W'(q) < cfg_i.key_length) && (key_m[q] < key_m[p])) begin
          rank[p] = rank[p] + IW'(1);
        end
      end
    end
  end

  // Inverse ranks: which key position ranks i-th
  always_comb begin
    for (int i = 0; i < MAX_KEY; i++) begin
      ord[i] = '0;
      for (int p = 0; p < MAX_KEY; p++) begin
        if ((LEN_W'(p) < cfg_i.key_length) && (rank[p] == IW'(i))) begin
          ord[i] = IW'(p);
        end
      end
    end
  end

  // Block contents: stored entries, the new symbol, then padding
  always_comb begin
    for (int p = 0; p < MAX_KEY; p++) begin
      if (CW'(p) < fill_new) begin
        syms_o[p] = (room && (CW'(p) == fill_q)) ? sym_m : store_q[p];
      end else begin
        syms_o[p] = pad_m;
      end
      sel_o[p] = cfg_i.direction ? rank[p] : ord[p];
    end
  end

  // Classify the accepted item
  always_comb begin
    fill_d = fill_q;
    push_o = 1'b0;
    ctl_o  = '{len: LEN_W'(1), last: 1'b1, status: STATUS_BAD_KEY};
    if (in_acc) begin
      if (!key_ok) begin
        fill_d = '0;
        push_o = in_item_i.last;
      end else if (short_blk && !in_item_i.last) begin
        fill_d = fill_new;
      end else if (short_blk && cfg_i.direction) begin
        fill_d = '0;
        push_o = 1'b1;
        ctl_o  = '{len: LEN_W'(1), last: 1'b1, status: STATUS_BAD_LEN};
      end else begin
        fill_d = '0;
        push_o = 1'b1;
        ctl_o  = '{len: cfg_i.key_length, last: in_item_i.last, status: STATUS_OK};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Gathering store, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && key_ok && room) begin
      store_q[fill_q[IW-1:0]] <= sym_m;
    end
  end

endmodule

`default_nettype wire

>>> rtl/kbt_queue.sv
`default_nettype none

module kbt_queue
  import kbt_pkg::*;
#(
  parameter int unsigned MAX_KEY = KBT_MAX_KEY,
  localparam int unsigned IW  = $clog2(MAX_KEY),
  localparam int unsigned QPW = $clog2(QDEPTH),
  localparam int unsigned QCW = $clog2(QDEPTH + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire logic [MAX_KEY-1:0][SYM_W-1:0]    syms_i,
  input  wire logic [MAX_KEY-1:0][IW-1:0]       sel_i,
  input  wire blk_ctl_t                         ctl_i,
  output logic                                  full_o,
  input  wire logic                             pop_i,
  output logic                                  head_valid_o,
  output logic [MAX_KEY-1:0][SYM_W-1:0]         head_syms_o,
  output logic [MAX_KEY-1:0][IW-1:0]            head_sel_o,
  output blk_ctl_t                              head_ctl_o
);

  logic [QDEPTH-1:0][MAX_KEY-1:0][SYM_W-1:0] syms_q;
  logic [QDEPTH-1:0][MAX_KEY-1:0][IW-1:0]    sel_q;
  blk_ctl_t [QDEPTH-1:0]                     ctl_q;
  logic [QPW-1:0]                            wp_q, wp_d, rp_q, rp_d;
  logic [QCW-1:0]                            count_q, count_d;

  assign full_o       = (count_q == QCW'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_syms_o  = syms_q[rp_q];
  assign head_sel_o   = sel_q[rp_q];
  assign head_ctl_o   = ctl_q[rp_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    count_d = count_q;
    if (push_i) begin
      wp_d = (wp_q == QPW'(QDEPTH - 1)) ? '0 : wp_q + QPW'(1);
    end
    if (pop_i) begin
      rp_d = (rp_q == QPW'(QDEPTH - 1)) ? '0 : rp_q + QPW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  // Block slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      syms_q[wp_q] <= syms_i;
      sel_q[wp_q]  <= sel_i;
      ctl_q[wp_q]  <= ctl_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("block queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("block queue read while empty");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + QCW'(1)))
    else $error("block queue count lost a write");
`endif

endmodule

`default_nettype wire

>>> rtl/kbt_back.sv
`default_nettype none

module kbt_back
  import kbt_pkg::*;
#(
  parameter int unsigned MAX_KEY = KBT_MAX_KEY,
  localparam int unsigned IW = $clog2(MAX_KEY)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            head_valid_i,
  input  wire logic [MAX_KEY-1:0][SYM_W-1:0]   head_syms_i,
  input  wire logic [MAX_KEY-1:0][IW-1:0]      head_sel_i,
  input  wire blk_ctl_t                        head_ctl_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output out_item_t                            out_item_o
);

  logic [IW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;
  logic          load, advance, blk_end;

  assign load    = !out_valid_q || !out_stall_i;
  assign advance = head_valid_i && load;
  assign blk_end = ((LEN_W'(cnt_q) + LEN_W'(1)) == head_ctl_i.len);
  assign pop_o   = advance && blk_end;

  // Next result from the head block
  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = head_valid_i;
    end
    if (advance) begin
      out_d.out_symbol = (head_ctl_i.status == STATUS_OK) ?
                         head_syms_i[head_sel_i[cnt_q]] : '0;
      out_d.block_end  = blk_end;
      out_d.text_end   = blk_end && head_ctl_i.last;
      out_d.status     = head_ctl_i.status;
      cnt_d            = blk_end ? '0 : cnt_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/keyed_block_transposition.sv
`default_nettype none
// A completed block goes into a queue slot; its first result then enters the output register.
// One item per cycle in and out while not stalled; blocks give key_length results, one if bad.
// A two-block queue between gathering and output lets a block gather while the previous drains.
// Input stalls only while both queue slots are occupied; a slot frees as its last result
// enters the output register.
// Reset clears the fill count, queue, output valid and registers (pad symbol to all ones);
// the gathering store holds no reset value and is only read where written.

module keyed_block_transposition
  import kbt_pkg::*;
#(
  parameter int unsigned MAX_KEY     = KBT_MAX_KEY,
  parameter int unsigned SYMBOL_BITS = KBT_SYMBOL_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o
);

  localparam int unsigned IW = $clog2(MAX_KEY);

  cfg_t                          cfg_q, cfg_d;
  logic                          q_full, push, pop, head_valid;
  logic [MAX_KEY-1:0][SYM_W-1:0] f_syms, h_syms;
  logic [MAX_KEY-1:0][IW-1:0]    f_sel, h_sel;
  blk_ctl_t                      f_ctl, h_ctl;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIRECTION:   cfg_d.direction   = cfg_data_i[0];
        CFG_KEY_LENGTH:  cfg_d.key_length  = cfg_data_i[LEN_W-1:0];
        CFG_KEY_SYMBOLS: cfg_d.key_symbols = cfg_data_i[KEY_W-1:0];
        CFG_PAD_SYMBOL:  cfg_d.pad_symbol  = cfg_data_i[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{direction: 1'b0, key_length: '0, key_symbols: '0,
                 pad_symbol: {SYM_W{1'b1}}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  kbt_front #(
    .MAX_KEY     (MAX_KEY),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .syms_o     (f_syms),
    .sel_o      (f_sel),
    .ctl_o      (f_ctl)
  );

  kbt_queue #(
    .MAX_KEY (MAX_KEY)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .syms_i       (f_syms),
    .sel_i        (f_sel),
    .ctl_i        (f_ctl),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_syms_o  (h_syms),
    .head_sel_o   (h_sel),
    .head_ctl_o   (h_ctl)
  );

  kbt_back #(
    .MAX_KEY (MAX_KEY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_syms_i  (h_syms),
    .head_sel_i   (h_sel),
    .head_ctl_i   (h_ctl),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire
